// ===== src/oal_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered array list package
// Shared widths, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package oal_pkg;

  // Default number of list cells.
  localparam int DEFAULT_LIST_DEPTH = 8;

  // Fixed field widths of the request and result items.
  localparam int OP_W   = 3;
  localparam int POS_W  = 4;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 4;
  localparam int STAT_W = 2;

  // List operations carried in a request.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT  = 3'd0,
    OP_APPEND     = 3'd1,
    OP_DELETE_AT  = 3'd2,
    OP_DELETE_KEY = 3'd3,
    OP_REPLACE    = 3'd4,
    OP_READ       = 3'd5,
    OP_SEARCH     = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // What every cell of the chain does in the update cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_cmd_t;

  // Command broadcast along the chain.
  typedef struct packed {
    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

// ===== src/oal_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered array list cell
// Holds one list entry, compares it with the key and takes data from the
// new value or from either neighbour when the list shifts.
// ----------------------------------------------------------------------------
module oal_cell (
  input  logic                               clk,
  input  oal_pkg::cell_ctl_t                 ctl,
  input  logic                               at,
  input  logic                               above,
  input  logic signed [oal_pkg::DATA_W-1:0]  left_data,
  input  logic signed [oal_pkg::DATA_W-1:0]  right_data,
  input  logic signed [oal_pkg::DATA_W-1:0]  key,
  output logic signed [oal_pkg::DATA_W-1:0]  data,
  output logic                               match
);

  import oal_pkg::*;

  logic signed [DATA_W-1:0] data_next;

  // Select the next entry from the command and this cell's place in it.
  always_comb begin
    data_next = data;
    case (ctl.cmd)
      CELL_WRITE: begin
        if (at) data_next = ctl.value;
      end
      CELL_SHIFT_UP: begin
        if (above) begin
          data_next = left_data;
        end else if (at) begin
          data_next = ctl.value;
        end
      end
      CELL_SHIFT_DOWN: begin
        if (at || above) data_next = right_data;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // Entry register; its contents matter only below the fill count.
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Key compare for search and delete by key.
  assign match = (data == key);

endmodule

// ===== src/ordered_array_list_unit.sv =====
// ----------------------------------------------------------------------------
// Ordered array list unit
// A bounded ordered list of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on the s_ group (op, position and value) and produces
// exactly one result on the m_ group (data, found flag, length, status).
// When a request is taken, every cell compares its entry with the key and the
// match vector is registered. Once the output register is free, the command
// is broadcast along the chain, every cell shifts, writes or holds at once,
// and the result is loaded into the output register. A new request is taken
// only once the update of the one before has been done; the compare and
// update steps of the cell chain set that limit.
// A new request is taken while an earlier result still waits. If the
// receiver stalls, the update cycle waits until the output register is free,
// so no result is lost or reordered.
// Reset clears the fill count and the handshake state; cell contents are
// left as they are and are never visible above the fill count.
// ----------------------------------------------------------------------------
module ordered_array_list_unit #(
  parameter int LIST_DEPTH = oal_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op [2:0], pos [6:3], value [38:7], zero [39]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // data [31:0], found [32], length [36:33], status [38:37], zero [39]
  output logic [39:0] m_tdata
);

  import oal_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request registers and handshake state.
  logic                     busy;
  op_t                      req_op;
  logic [POS_W-1:0]         req_pos;
  logic signed [DATA_W-1:0] req_value;
  logic [LIST_DEPTH-1:0]    match_q;
  logic [CNT_W-1:0]         count;

  logic                     s_fire;
  logic                     exec_fire;
  op_t                      in_op;
  logic [POS_W-1:0]         in_pos;
  logic signed [DATA_W-1:0] in_value;

  // Cell chain signals.
  logic signed [DATA_W-1:0] cell_data [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]    cell_match;
  logic [LIST_DEPTH-1:0]    cell_valid;
  logic [LIST_DEPTH-1:0]    idx_at;
  logic [LIST_DEPTH-1:0]    idx_above;
  logic [LIST_DEPTH-1:0]    key_at;
  logic [LIST_DEPTH-1:0]    key_above;
  logic [LIST_DEPTH-1:0]    at_vec;
  logic [LIST_DEPTH-1:0]    above_vec;
  cell_ctl_t                ctl;

  // Update decode.
  logic [CMP_W-1:0]         count_ext;
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         target;
  logic [CMP_W-1:0]         count_next;
  logic                     use_key;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] sel_data;
  logic signed [DATA_W-1:0] res_data;
  logic                     res_found;
  status_t                  res_status;
  logic                     is_full;
  logic                     any_match;

  assign in_op    = op_t'(s_tdata[2:0]);
  assign in_pos   = s_tdata[6:3];
  assign in_value = s_tdata[38:7];

  assign s_tready  = !busy;
  assign s_fire    = s_tvalid && s_tready;
  assign exec_fire = busy && (!m_tvalid || m_tready);

  assign count_ext = CMP_W'(count);
  assign pos_ext   = CMP_W'(req_pos);
  assign is_full   = (count_ext == CMP_W'(LIST_DEPTH));
  assign any_match = |match_q;

  // First matching entry and the entries above it.
  assign key_at    = match_q & (~match_q + 1'b1);
  assign key_above = ~(key_at - 1'b1) & ~key_at;

  // Per-cell position decode against the target index.
  genvar gi;
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_decode
      assign cell_valid[gi] = (CMP_W'(gi) < count_ext);
      assign idx_at[gi]     = (CMP_W'(gi) == target);
      assign idx_above[gi]  = (CMP_W'(gi) > target);
    end
  endgenerate

  assign at_vec    = use_key ? key_at : idx_at;
  assign above_vec = use_key ? key_above : idx_above;

  // Entry at the selected position, for read and delete.
  always_comb begin
    sel_data = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (at_vec[i]) sel_data = sel_data | cell_data[i];
    end
  end

  // Operation decode: status, cell command and next fill count.
  always_comb begin
    target     = pos_ext;
    use_key    = 1'b0;
    cmd        = CELL_HOLD;
    count_next = count_ext;
    res_data   = '0;
    res_found  = 1'b0;
    res_status = ST_OK;
    case (req_op)
      OP_INSERT_AT: begin
        if (is_full) begin
          res_status = ST_FULL;
        end else if (pos_ext > count_ext) begin
          res_status = ST_BAD_POS;
        end else begin
          cmd        = CELL_SHIFT_UP;
          count_next = count_ext + 1'b1;
        end
      end
      OP_APPEND: begin
        target = count_ext;
        if (is_full) begin
          res_status = ST_FULL;
        end else begin
          cmd        = CELL_WRITE;
          count_next = count_ext + 1'b1;
        end
      end
      OP_DELETE_AT: begin
        if (pos_ext >= count_ext) begin
          res_status = ST_BAD_POS;
        end else begin
          cmd        = CELL_SHIFT_DOWN;
          res_data   = sel_data;
          count_next = count_ext - 1'b1;
        end
      end
      OP_DELETE_KEY: begin
        use_key = 1'b1;
        if (!any_match) begin
          res_status = ST_NOT_FOUND;
        end else begin
          cmd        = CELL_SHIFT_DOWN;
          res_data   = sel_data;
          res_found  = 1'b1;
          count_next = count_ext - 1'b1;
        end
      end
      OP_REPLACE: begin
        if (pos_ext >= count_ext) begin
          res_status = ST_BAD_POS;
        end else begin
          cmd = CELL_WRITE;
        end
      end
      OP_READ: begin
        if (pos_ext >= count_ext) begin
          res_status = ST_BAD_POS;
        end else begin
          res_data = sel_data;
        end
      end
      OP_SEARCH: begin
        if (any_match) begin
          res_found = 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Command broadcast; cells hold unless the update is taken this cycle.
  assign ctl.cmd   = exec_fire ? cmd : CELL_HOLD;
  assign ctl.value = req_value;

  // Chain of cells, each fed by its lower and upper neighbour.
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      logic signed [DATA_W-1:0] left_d;
      logic signed [DATA_W-1:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = cell_data[gi-1];
      end
      if (gi == LIST_DEPTH - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = cell_data[gi+1];
      end
      oal_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .at         (at_vec[gi]),
        .above      (above_vec[gi]),
        .left_data  (left_d),
        .right_data (right_d),
        .key        (in_value),
        .data       (cell_data[gi]),
        .match      (cell_match[gi])
      );
    end
  endgenerate

  // Handshake state, fill count and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_fire) begin
        busy <= 1'b1;
      end else if (exec_fire) begin
        busy <= 1'b0;
      end
      if (exec_fire) begin
        count    <= CNT_W'(count_next);
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      req_op    <= in_op;
      req_pos   <= in_pos;
      req_value <= in_value;
      match_q   <= cell_match & cell_valid;
    end
    if (exec_fire) begin
      m_tdata <= {1'b0, res_status, count_next[LEN_W-1:0], res_found, res_data};
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered array list unit testbench
// Drives list requests through the stream slave port and keeps its own
// mirror of the list contents and fill count. Each accepted request updates
// the mirror and queues the reply it should produce; every result transfer
// is compared field by field with the oldest queued reply. Both sides idle
// in random bursts except in the directed and closing phases.
// ----------------------------------------------------------------------------
module testbench;
  import oal_pkg::*;

  localparam int LIST_DEPTH = DEFAULT_LIST_DEPTH;
  localparam int CYCLE_LIMIT = 200000;

  // One reply as the list should produce it.
  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic                     found;
    logic [LEN_W-1:0]         length;
    status_t                  status;
  } list_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  // Mirror of the list and the replies still owed by the block.
  logic signed [DATA_W-1:0] mirror_cells [LIST_DEPTH];
  int                       mirror_count = 0;
  list_reply_t              owed_replies [$];

  // Run control and bookkeeping.
  bit src_idle_en = 1'b0;
  bit sink_idle_en = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int accepted_count = 0;
  int reply_count = 0;
  int op_tally [8];
  int status_tally [4];

  ordered_array_list_unit #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d replies outstanding.",
               cycle_count, owed_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Removes one entry from the mirror, closing the gap.
  function automatic void drop_cell(input int idx);
    int i;
    for (i = idx; i + 1 < mirror_count; i++) mirror_cells[i] = mirror_cells[i + 1];
    mirror_count--;
  endfunction

  // Applies one request to the mirror and returns the reply it must give.
  function automatic list_reply_t apply_list_op(input op_t op, input logic [POS_W-1:0] pos,
                                                input logic signed [DATA_W-1:0] value);
    list_reply_t r;
    int hit;
    int i;
    r.data = '0;
    r.found = 1'b0;
    r.status = ST_OK;
    // First entry from position 0 that equals the key.
    hit = -1;
    for (i = mirror_count - 1; i >= 0; i--) begin
      if (mirror_cells[i] == value) hit = i;
    end
    case (op)
      OP_INSERT_AT: begin
        if (mirror_count >= LIST_DEPTH) r.status = ST_FULL;
        else if (int'(pos) > mirror_count) r.status = ST_BAD_POS;
        else begin
          for (i = mirror_count; i > int'(pos); i--) mirror_cells[i] = mirror_cells[i - 1];
          mirror_cells[pos] = value;
          mirror_count++;
        end
      end
      OP_APPEND: begin
        if (mirror_count >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          mirror_cells[mirror_count] = value;
          mirror_count++;
        end
      end
      OP_DELETE_AT: begin
        if (int'(pos) >= mirror_count) r.status = ST_BAD_POS;
        else begin
          r.data = mirror_cells[pos];
          drop_cell(int'(pos));
        end
      end
      OP_DELETE_KEY: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else begin
          r.data = mirror_cells[hit];
          r.found = 1'b1;
          drop_cell(hit);
        end
      end
      OP_REPLACE: begin
        if (int'(pos) >= mirror_count) r.status = ST_BAD_POS;
        else mirror_cells[pos] = value;
      end
      OP_READ: begin
        if (int'(pos) >= mirror_count) r.status = ST_BAD_POS;
        else r.data = mirror_cells[pos];
      end
      OP_SEARCH: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else r.found = 1'b1;
      end
      default: begin
        mirror_count = 0;
      end
    endcase
    r.length = LEN_W'(mirror_count);
    return r;
  endfunction

  // Sends one request, with an occasional idle burst first, and records the
  // reply it owes once the transfer has taken place.
  task automatic send_request(input op_t op, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] value);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, value, pos, op};
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    owed_replies.push_back(apply_list_op(op, pos, value));
    op_tally[op]++;
    accepted_count++;
  endtask

  // Compares one result transfer with the oldest owed reply.
  task automatic check_reply(input logic [39:0] word);
    list_reply_t want;
    status_t got_status;
    got_status = status_t'(word[38:37]);
    if (owed_replies.size() == 0) begin
      $error("result transfer with no request outstanding: data %0d status %0d",
             $signed(word[31:0]), word[38:37]);
      mismatch_count++;
    end else begin
      want = owed_replies.pop_front();
      reply_count++;
      status_tally[got_status]++;
      if (word[31:0] !== want.data) begin
        $error("data: expected %0d, got %0d", want.data, $signed(word[31:0]));
        mismatch_count++;
      end
      if (word[32] !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, word[32]);
        mismatch_count++;
      end
      if (word[36:33] !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, word[36:33]);
        mismatch_count++;
      end
      if (word[38:37] !== want.status) begin
        $error("status: expected %s, got %0d", want.status.name(), word[38:37]);
        mismatch_count++;
      end
    end
  endtask

  // Result side: checks each transfer and stalls in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) check_reply(m_tdata);
      if (stall_left == 0 && sink_idle_en && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Value source: mostly keys already in the list, small values and the
  // extremes, so that searches and deletes by key find matches.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel <= 2 && mirror_count > 0) return mirror_cells[$urandom_range(0, mirror_count - 1)];
    if (sel == 3) return DATA_W'($signed($urandom_range(0, 7)) - 4);
    if (sel == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  // Position source: mostly from 0 up to the current length, sometimes up to the depth.
  function automatic logic [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 3) != 0) return POS_W'($urandom_range(0, mirror_count));
    return POS_W'($urandom_range(0, LIST_DEPTH));
  endfunction

  function automatic op_t pick_op();
    if ($urandom_range(0, 31) == 0) return OP_CLEAR;
    return op_t'($urandom_range(0, 6));
  endfunction

  // Empty-list errors, extremes of the values, filling to full, duplicate
  // keys, deletes at both ends and clear.
  task automatic test_directed_edges();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    send_request(OP_READ, 4'd0, 32'sd0);
    send_request(OP_DELETE_AT, 4'd0, 32'sd0);
    send_request(OP_DELETE_KEY, 4'd0, 32'sd5);
    send_request(OP_SEARCH, 4'd0, 32'sd5);
    send_request(OP_REPLACE, 4'd0, 32'sd9);
    send_request(OP_INSERT_AT, 4'd1, 32'sd9);
    send_request(OP_INSERT_AT, 4'd0, 32'sh8000_0000);
    send_request(OP_APPEND, 4'd0, 32'sh7FFF_FFFF);
    send_request(OP_APPEND, 4'd15, -32'sd1);
    send_request(OP_INSERT_AT, 4'd1, 32'sd5);
    send_request(OP_INSERT_AT, 4'd4, 32'sd5);
    send_request(OP_APPEND, 4'd0, 32'sd0);
    send_request(OP_APPEND, 4'd0, 32'sh5555_AAAA);
    send_request(OP_INSERT_AT, 4'd0, 32'sd5);
    send_request(OP_APPEND, 4'd0, 32'sd1);
    send_request(OP_INSERT_AT, 4'd8, 32'sd1);
    send_request(OP_READ, 4'd8, 32'sd0);
    send_request(OP_READ, 4'd7, 32'sd0);
    send_request(OP_SEARCH, 4'd0, 32'sd5);
    send_request(OP_REPLACE, 4'd7, 32'shAAAA_5555);
    send_request(OP_DELETE_KEY, 4'd0, 32'sd5);
    send_request(OP_DELETE_AT, 4'd0, 32'sd0);
    send_request(OP_DELETE_AT, 4'd5, 32'sd0);
    send_request(OP_SEARCH, 4'd0, 32'sd12345);
    send_request(OP_CLEAR, 4'd0, 32'sd0);
    send_request(OP_READ, 4'd0, 32'sd0);
  endtask

  // Unshaped random requests with idling on both sides.
  task automatic test_random_mix(input int count);
    int n;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    for (n = 0; n < count; n++) send_request(pick_op(), pick_pos(), pick_value());
  endtask

  // Rounds that fill the list to a random level, work on it and drain it,
  // with a little noise mixed in.
  task automatic test_fill_and_drain(input int count);
    int stop_at;
    int target;
    int k;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    stop_at = accepted_count + count;
    while (accepted_count < stop_at) begin
      target = $urandom_range(2, LIST_DEPTH);
      while (mirror_count < target) begin
        if ($urandom_range(0, 1) == 0) send_request(OP_APPEND, pick_pos(), pick_value());
        else send_request(OP_INSERT_AT, POS_W'($urandom_range(0, mirror_count)), pick_value());
      end
      // Work on the filled list, including refused growth when full.
      repeat ($urandom_range(2, 8)) begin
        case ($urandom_range(0, 5))
          0: send_request(OP_READ, pick_pos(), 32'sd0);
          1: send_request(OP_REPLACE, pick_pos(), pick_value());
          2: send_request(OP_SEARCH, pick_pos(), pick_value());
          3: send_request(OP_APPEND, pick_pos(), pick_value());
          4: send_request(OP_INSERT_AT, pick_pos(), pick_value());
          default: send_request(pick_op(), pick_pos(), pick_value());
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        send_request(OP_CLEAR, pick_pos(), pick_value());
      end else begin
        k = 0;
        while (mirror_count > 0 && k < 4 * LIST_DEPTH) begin
          if ($urandom_range(0, 1) == 0)
            send_request(OP_DELETE_AT, POS_W'($urandom_range(0, mirror_count - 1)), pick_value());
          else send_request(OP_DELETE_KEY, pick_pos(), pick_value());
          k++;
        end
      end
    end
  endtask

  // Closing phase: back-to-back transfers with no idling on either side.
  task automatic test_steady_stream(input int count);
    int n;
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 1) == 0 && mirror_count < LIST_DEPTH)
        send_request(OP_APPEND, pick_pos(), pick_value());
      else send_request(pick_op(), pick_pos(), pick_value());
    end
  endtask

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_random_mix(600);
    test_fill_and_drain(600);
    test_steady_stream(520);
    s_tvalid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d requests: insert %0d, append %0d, delete %0d, delete by key %0d,",
             accepted_count, op_tally[OP_INSERT_AT], op_tally[OP_APPEND],
             op_tally[OP_DELETE_AT], op_tally[OP_DELETE_KEY]);
    $display("replace %0d, read %0d, search %0d, clear %0d; replies ok %0d, bad position %0d, full %0d, not found %0d.",
             op_tally[OP_REPLACE], op_tally[OP_READ], op_tally[OP_SEARCH], op_tally[OP_CLEAR],
             status_tally[ST_OK], status_tally[ST_BAD_POS], status_tally[ST_FULL],
             status_tally[ST_NOT_FOUND]);
    if (mismatch_count == 0 && owed_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
